@@ src/rgbhls_pkg.sv @@
`default_nettype none

package rgbhls_pkg;

    localparam int HUE_FRAC_BITS = 8;
    localparam int N_CELLS       = (HUE_FRAC_BITS + 1 > 8) ? HUE_FRAC_BITS + 1 : 8;
    localparam int NUM_W         = N_CELLS + 8;
    localparam int HUE_W         = HUE_FRAC_BITS + 4;

    localparam logic [2:0] BASE_RED   = 3'd0;
    localparam logic [2:0] BASE_GREEN = 3'd2;
    localparam logic [2:0] BASE_BLUE  = 3'd4;
    localparam logic [2:0] BASE_WRAP  = 3'd6;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [10:0] hue;
        logic [8:0]  lightness_sum;
        logic [7:0]  saturation;
        logic        achromatic;
    } t_pix_out;

    typedef struct packed {
        logic [7:0]         rem;
        logic [N_CELLS-1:0] num;
        logic [N_CELLS-1:0] quot;
        logic [7:0]         divisor;
    } t_div_lane;

    typedef struct packed {
        t_div_lane  hue_lane;
        t_div_lane  sat_lane;
        logic [2:0] base;
        logic       neg;
        logic [8:0] sum;
        logic       achro;
    } t_cell_data;

endpackage

`default_nettype wire

@@ src/rgbhls_prep.sv @@
`default_nettype none

module rgbhls_prep import rgbhls_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  t_pix_in     i_data,
    output logic        o_ready,
    output logic        o_valid,
    output t_cell_data  o_data,
    input  wire         i_ready
);

    logic       r_valid;
    logic       n_valid;
    t_cell_data r_data;
    t_cell_data n_data;

    logic [7:0]       mx;
    logic [7:0]       mn;
    logic [7:0]       delta;
    logic [8:0]       sum;
    logic [7:0]       denom;
    logic [7:0]       p;
    logic [7:0]       q;
    logic [7:0]       ad;
    logic [NUM_W-1:0] hx;
    logic [NUM_W-1:0] sx;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        mx = i_data.red;
        mn = i_data.red;
        if (i_data.green > mx) mx = i_data.green;
        if (i_data.blue > mx)  mx = i_data.blue;
        if (i_data.green < mn) mn = i_data.green;
        if (i_data.blue < mn)  mn = i_data.blue;
        delta = mx - mn;
        sum   = {1'b0, mx} + {1'b0, mn};
        denom = (sum < 9'd255) ? sum[7:0] : 8'(9'd510 - sum);

        if (i_data.red == mx) begin
            p = i_data.green;
            q = i_data.blue;
            n_data.base = (i_data.green >= i_data.blue) ? BASE_RED : BASE_WRAP;
        end else if (i_data.green == mx) begin
            p = i_data.blue;
            q = i_data.red;
            n_data.base = BASE_GREEN;
        end else begin
            p = i_data.red;
            q = i_data.green;
            n_data.base = BASE_BLUE;
        end
        n_data.neg = p < q;
        ad = (p >= q) ? p - q : q - p;
        hx = NUM_W'(ad) << HUE_FRAC_BITS;
        sx = NUM_W'({8'd0, delta} * 16'd255);

        n_data.hue_lane.rem     = hx[NUM_W-1:N_CELLS];
        n_data.hue_lane.num     = hx[N_CELLS-1:0];
        n_data.hue_lane.quot    = '0;
        n_data.hue_lane.divisor = delta;
        n_data.sat_lane.rem     = sx[NUM_W-1:N_CELLS];
        n_data.sat_lane.num     = sx[N_CELLS-1:0];
        n_data.sat_lane.quot    = '0;
        n_data.sat_lane.divisor = denom;
        n_data.sum   = sum;
        n_data.achro = (delta == 8'd0);

        n_valid = o_ready ? i_valid : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

@@ src/rgbhls_cell.sv @@
`default_nettype none

module rgbhls_cell import rgbhls_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  t_cell_data  i_data,
    output logic        o_ready,
    output logic        o_valid,
    output t_cell_data  o_data,
    input  wire         i_ready
);

    function automatic t_div_lane div_step(input t_div_lane lane);
        logic [8:0] t;
        logic       ge;
        t_div_lane  res;
        t  = {lane.rem, lane.num[N_CELLS-1]};
        ge = t >= {1'b0, lane.divisor};
        res.rem     = ge ? 8'(t - {1'b0, lane.divisor}) : t[7:0];
        res.num     = lane.num << 1;
        res.quot    = {lane.quot[N_CELLS-2:0], ge};
        res.divisor = lane.divisor;
        return res;
    endfunction

    logic       r_valid;
    logic       n_valid;
    t_cell_data r_data;
    t_cell_data n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data          = i_data;
        n_data.hue_lane = div_step(i_data.hue_lane);
        n_data.sat_lane = div_step(i_data.sat_lane);
        n_valid         = o_ready ? i_valid : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

@@ src/rgbhls_out.sv @@
`default_nettype none

module rgbhls_out import rgbhls_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  t_cell_data  i_data,
    output logic        o_ready,
    output logic        o_valid,
    output t_pix_out    o_data,
    input  wire         i_ready
);

    logic           r_valid;
    logic           n_valid;
    t_pix_out       r_data;
    t_pix_out       n_data;
    logic [HUE_W-1:0] base_s;
    logic [HUE_W-1:0] quo;
    logic [HUE_W-1:0] quo_ceil;
    logic [HUE_W-1:0] hue;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        base_s   = HUE_W'(i_data.base) << HUE_FRAC_BITS;
        quo      = HUE_W'(i_data.hue_lane.quot);
        quo_ceil = quo + HUE_W'(i_data.hue_lane.rem != 8'd0);
        hue      = i_data.neg ? base_s - quo_ceil : base_s + quo;

        n_data.lightness_sum = i_data.sum;
        n_data.achromatic    = i_data.achro;
        n_data.hue           = i_data.achro ? 11'd0 : 11'(hue);
        n_data.saturation    = i_data.achro ? 8'd0 : i_data.sat_lane.quot[7:0];

        n_valid = o_ready ? i_valid : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

@@ src/rgb_to_hls_pixel_core.sv @@
`default_nettype none

// Converts one 8-bit RGB pixel per transaction into hue (sextants with
// HUE_FRAC_BITS fraction bits), the sum max+min and a saturation scaled to
// 255, plus an achromatic flag. The block accepts one pixel every clock
// while the output is not stalled. Each result passes in turn through an
// input setup stage, a row of divider cells, each of which resolves one
// quotient bit of both the hue and the saturation division, and an output
// stage. Empty stages still take new pixels while a result waits, and once
// every stage holds a pixel a stall on the output stalls the input in the
// same cycle.

module rgb_to_hls_pixel_core import rgbhls_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    input  t_pix_in   i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_pix_out  o_out_data,
    input  wire       i_out_stall
);

    logic       link_valid [N_CELLS+1];
    t_cell_data link_data  [N_CELLS+1];
    logic       link_ready [N_CELLS+1];
    logic       prep_ready;

    assign o_in_stall = !prep_ready;

    rgbhls_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_ready (prep_ready),
        .o_valid (link_valid[0]),
        .o_data  (link_data[0]),
        .i_ready (link_ready[0])
    );

    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        rgbhls_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (link_valid[k]),
            .i_data  (link_data[k]),
            .o_ready (link_ready[k]),
            .o_valid (link_valid[k+1]),
            .o_data  (link_data[k+1]),
            .i_ready (link_ready[k+1])
        );
    end

    rgbhls_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (link_valid[N_CELLS]),
        .i_data  (link_data[N_CELLS]),
        .o_ready (link_ready[N_CELLS]),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_ready (!i_out_stall)
    );

endmodule

`default_nettype wire

@@ src/rgbhls_checker.sv @@
`default_nettype none

module rgbhls_checker import rgbhls_pkg::*; (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_in_stall,
    input wire       o_out_valid,
    input t_pix_out  o_out_data,
    input wire       i_out_stall
);

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("Stalled result transaction changed.");

    a_no_input_stall: assert property (@(posedge i_clk)
        !i_out_stall |-> !o_in_stall)
        else $error("Input stalled while the output is free.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result transaction offered right after reset.");

    a_achro_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.achromatic |->
            o_out_data.hue == 11'd0 && o_out_data.saturation == 8'd0)
        else $error("Achromatic pixel with nonzero hue or saturation.");

endmodule

bind rgb_to_hls_pixel_core rgbhls_checker u_rgbhls_checker (.*);

`default_nettype wire

@@ tb/rgb_to_hls_pixel_core_tb.sv @@
`default_nettype none

module rgb_to_hls_pixel_core_tb import rgbhls_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_PIXELS  = 1500;
    localparam int IDLE_PERCENT   = 19;
    localparam int CALM_FIRST     = 500;
    localparam int CALM_LAST      = 799;
    localparam int DRAIN_AT       = 1000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 2000;

    class hls_scoreboard;
        t_pix_out pending_hls[$];
        int       errors = 0;

        function automatic int unsigned sextant_hue(int unsigned base, int unsigned p,
                                                    int unsigned q, int unsigned span);
            int unsigned one;
            one = 1 << HUE_FRAC_BITS;
            if (p >= q) begin
                return base * one + ((p - q) << HUE_FRAC_BITS) / span;
            end
            return base * one - ((((q - p) << HUE_FRAC_BITS) + span - 1) / span);
        endfunction

        function automatic t_pix_out predict_hls(t_pix_in px);
            int unsigned r, g, b, hi, lo, span, total, hue_fx, sat;
            t_pix_out    res;
            r = px.red;
            g = px.green;
            b = px.blue;
            hi = r;
            lo = r;
            if (g > hi) hi = g;
            if (b > hi) hi = b;
            if (g < lo) lo = g;
            if (b < lo) lo = b;
            span = hi - lo;
            total = hi + lo;
            hue_fx = 0;
            sat = 0;
            if (span != 0) begin
                sat = (total < 255) ? (255 * span) / total : (255 * span) / (510 - total);
                if (r == hi) begin
                    hue_fx = (g >= b) ? sextant_hue(int'(BASE_RED), g, b, span)
                                      : sextant_hue(int'(BASE_WRAP), g, b, span);
                end else if (g == hi) begin
                    hue_fx = sextant_hue(int'(BASE_GREEN), b, r, span);
                end else begin
                    hue_fx = sextant_hue(int'(BASE_BLUE), r, g, span);
                end
            end
            res.hue = hue_fx[10:0];
            res.lightness_sum = total[8:0];
            res.saturation = sat[7:0];
            res.achromatic = (span == 0);
            return res;
        endfunction

        function void note_pixel(t_pix_in px);
            pending_hls.push_back(predict_hls(px));
        endfunction

        function int outstanding();
            return pending_hls.size();
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_pix_out got);
            t_pix_out want;
            if (pending_hls.size() == 0) begin
                report($sformatf("result transaction with none pending: %h", got));
                return;
            end
            want = pending_hls.pop_front();
            if (got.hue !== want.hue)
                report($sformatf("hue %0d, predicted %0d", got.hue, want.hue));
            if (got.lightness_sum !== want.lightness_sum)
                report($sformatf("lightness_sum %0d, predicted %0d",
                                 got.lightness_sum, want.lightness_sum));
            if (got.saturation !== want.saturation)
                report($sformatf("saturation %0d, predicted %0d",
                                 got.saturation, want.saturation));
            if (got.achromatic !== want.achromatic)
                report($sformatf("achromatic %0b, predicted %0b",
                                 got.achromatic, want.achromatic));
        endtask
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    t_pix_in  in_data = '0;
    logic     in_stall;
    logic     out_valid;
    t_pix_out out_data;
    logic     out_stall = 1'b0;
    logic     calm = 1'b0;
    int       quiet_cycles = 0;

    hls_scoreboard sb = new();

    rgb_to_hls_pixel_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall)
            sb.note_pixel(in_data);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end

    // The watchdog restarts whenever a transaction moves on either side.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic t_pix_in random_pixel();
        t_pix_in     px;
        logic [7:0]  corner [4];
        corner = '{8'd0, 8'd1, 8'd254, 8'd255};
        px = t_pix_in'($urandom);
        case ($urandom_range(9))
            0: begin
                px.green = px.red;
                px.blue = px.red;
            end
            1: px.green = px.red;
            2: px.blue = px.green;
            3: px.blue = px.red;
            4: begin
                px.red = corner[$urandom_range(3)];
                px.green = corner[$urandom_range(3)];
                px.blue = corner[$urandom_range(3)];
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic send_pixel(t_pix_in px);
        in_valid <= 1'b1;
        in_data <= px;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic idle_sender();
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    initial begin
        t_pix_in directed [$];
        directed = '{
            '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
            '{8'd255, 8'd0,   8'd0},   '{8'd0,   8'd255, 8'd0},   '{8'd0,   8'd0,   8'd255},
            '{8'd255, 8'd255, 8'd0},   '{8'd0,   8'd255, 8'd255}, '{8'd255, 8'd0,   8'd255},
            '{8'd200, 8'd10,  8'd50},  '{8'd1,   8'd0,   8'd0},   '{8'd0,   8'd1,   8'd0},
            '{8'd0,   8'd0,   8'd1},   '{8'd254, 8'd0,   8'd0},   '{8'd127, 8'd128, 8'd127},
            '{8'd100, 8'd50,  8'd200}, '{8'd50,  8'd100, 8'd200}, '{8'd254, 8'd255, 8'd254},
            '{8'd255, 8'd254, 8'd255}, '{8'd1,   8'd2,   8'd3},   '{8'd170, 8'd85,  8'd0},
            '{8'd200, 8'd100, 8'd150}, '{8'd10,  8'd200, 8'd100}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k]) begin
            idle_sender();
            send_pixel(directed[k]);
        end

        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            calm <= (n >= CALM_FIRST && n <= CALM_LAST);
            if (n == DRAIN_AT) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.outstanding() != 0) @(posedge clk);
            end
            idle_sender();
            send_pixel(random_pixel());
        end

        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
